// ===== design/hall_commutation_speed_estimator_core_assert.svh =====
// assertion macros for the hall commutation speed estimator
`ifndef HALL_COMMUTATION_SPEED_ESTIMATOR_CORE_ASSERT_SVH
`define HALL_COMMUTATION_SPEED_ESTIMATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HCSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcse check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define HCSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcse check failed");

`endif

// ===== design/hcse_pkg.sv =====
// shared types, constants and microcode for the hall commutation speed estimator
`default_nettype none

package hcse_pkg;

  localparam int PC_W       = 5;
  localparam int HALL_W     = 3;
  localparam int MODE_W     = 2;
  localparam int GAIN_W     = 11;
  localparam int CNT_W      = 16;
  localparam int RPM_W      = 17;
  localparam int PROD_W     = GAIN_W + RPM_W;
  localparam int Q_FRAC     = 10;
  localparam int ACC_W      = PROD_W - Q_FRAC + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DIV_CNT_W  = 5;

  localparam logic [CNT_W-1:0]     CNT_MAX   = '1;
  localparam logic [RPM_W-1:0]     RPM_MAX   = '1;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(RPM_W);

  // register reset values
  localparam logic [MODE_W-1:0] DRIVE_MODE_RST  = 2'd2;
  localparam logic [GAIN_W-1:0] GAIN_NEW_RST    = 11'd355;
  localparam logic [GAIN_W-1:0] GAIN_OLD_RST    = 11'd669;
  localparam logic [RPM_W-1:0]  RPM_COEFF_RST   = 17'd30000;
  localparam logic [CNT_W-1:0]  STALL_LIMIT_RST = 16'd2000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NEW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_OLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_COEFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 3'd4;

  // run modes that drive the bridge
  localparam logic [MODE_W-1:0] MODE_COMM_A = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMM_B = 2'd2;

  // bridge patterns
  localparam logic [2:0] PAT_NONE = 3'd0;
  localparam logic [2:0] PAT_Q16  = 3'd1;
  localparam logic [2:0] PAT_Q25  = 3'd2;
  localparam logic [2:0] PAT_Q32  = 3'd3;
  localparam logic [2:0] PAT_Q41  = 3'd4;
  localparam logic [2:0] PAT_Q54  = 3'd5;
  localparam logic [2:0] PAT_Q63  = 3'd6;

  typedef struct packed {
    logic [HALL_W-1:0] hall_code;
    logic              drive_enable;
  } in_item_t;

  typedef struct packed {
    logic             commutate;
    logic [2:0]       phase_pattern;
    logic [RPM_W-1:0] rpm_est;
    logic [RPM_W-1:0] rpm_est_filt;
    logic             stall_res;
  } out_item_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_ITEM, C_NOT_EN, C_SAME, C_DIV_BUSY, C_NO_STALL
  } cond_e;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_GO_CF, MUL_GN_TC, MUL_GO_RS, MUL_GN_RNOW
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_CF, WR_RNOW, WR_RS, WR_TC_CLR, WR_TC_INC, WR_STALL
  } wr_e;

  typedef struct packed {
    cond_e           cond;
    logic [PC_W-1:0] target;
    mul_sel_e        mul;
    acc_op_e         acc;
    wr_e             wr;
    logic            set_chg;
    logic            div_start;
    logic            emit;
  } uword_t;

  typedef struct packed {
    logic item;
    logic enable;
    logic same;
    logic div_busy;
    logic stall_hit;
    logic out_busy;
  } status_t;

  // named program addresses
  localparam logic [PC_W-1:0] ST_WAIT     = 5'd0;
  localparam logic [PC_W-1:0] ST_CHK_EN   = 5'd1;
  localparam logic [PC_W-1:0] ST_CHK_HALL = 5'd2;
  localparam logic [PC_W-1:0] ST_CHANGE   = 5'd3;
  localparam logic [PC_W-1:0] ST_DIV_WAIT = 5'd8;
  localparam logic [PC_W-1:0] ST_INC      = 5'd14;
  localparam logic [PC_W-1:0] ST_EMIT     = 5'd17;

  localparam uword_t UWORD_NOP = '{
    cond: C_NEVER, target: ST_WAIT, mul: MUL_NONE, acc: ACC_HOLD,
    wr: WR_NONE, set_chg: 1'b0, div_start: 1'b0, emit: 1'b0
  };

  function automatic logic [2:0] pattern_of_hall(input logic [HALL_W-1:0] hall);
    logic [2:0] p;
    case (hall)
      3'd1:    p = PAT_Q16;
      3'd2:    p = PAT_Q32;
      3'd3:    p = PAT_Q63;
      3'd4:    p = PAT_Q54;
      3'd5:    p = PAT_Q41;
      3'd6:    p = PAT_Q25;
      default: p = PAT_NONE;
    endcase
    return p;
  endfunction

  // microprogram
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UWORD_NOP;
    case (pc)
      ST_WAIT: begin
        w.cond   = C_NO_ITEM;
        w.target = ST_WAIT;
      end
      ST_CHK_EN: begin
        w.cond   = C_NOT_EN;
        w.target = ST_EMIT;
      end
      ST_CHK_HALL: begin
        w.cond   = C_SAME;
        w.target = ST_INC;
      end
      // count filter: old part, then new part
      ST_CHANGE: begin
        w.mul     = MUL_GO_CF;
        w.set_chg = 1'b1;
      end
      5'd4: begin
        w.acc = ACC_LOAD;
        w.mul = MUL_GN_TC;
      end
      5'd5: w.acc = ACC_ADD;
      5'd6: w.wr  = WR_CF;
      5'd7: begin
        w.wr        = WR_TC_CLR;
        w.div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        w.cond   = C_DIV_BUSY;
        w.target = ST_DIV_WAIT;
      end
      5'd9:  w.wr = WR_RNOW;
      // speed filter
      5'd10: w.mul = MUL_GO_RS;
      5'd11: begin
        w.acc = ACC_LOAD;
        w.mul = MUL_GN_RNOW;
      end
      5'd12: w.acc = ACC_ADD;
      5'd13: begin
        w.wr     = WR_RS;
        w.cond   = C_ALWAYS;
        w.target = ST_EMIT;
      end
      ST_INC: w.wr = WR_TC_INC;
      5'd15: begin
        w.cond   = C_NO_STALL;
        w.target = ST_EMIT;
      end
      5'd16: w.wr = WR_STALL;
      ST_EMIT: w.emit = 1'b1;
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/hcse_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module hcse_div
  import hcse_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RPM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  busy,
  output logic [RPM_W-1:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [RPM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     den_r, den_nxt;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       diff;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[RPM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_STEPS;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_nxt  = {quo_r[RPM_W-2:0], ge};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      busy_nxt = cnt_r != DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== design/hcse_seq.sv =====
// microcode sequencer: step counter, control store and jump logic
`default_nettype none

module hcse_seq
  import hcse_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire status_t st,
  output uword_t       uw,
  output logic         idle
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            cond_hit;

  // control word out of the program table
  always_comb begin
    uw   = ucode(pc_r);
    idle = pc_r == ST_WAIT;
  end

  // next step
  always_comb begin
    case (uw.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_ITEM:  cond_hit = !st.item;
      C_NOT_EN:   cond_hit = !st.enable;
      C_SAME:     cond_hit = st.same;
      C_DIV_BUSY: cond_hit = st.div_busy;
      C_NO_STALL: cond_hit = !st.stall_hit;
      default:    cond_hit = 1'b0;
    endcase
    if (uw.emit) begin
      pc_nxt = st.out_busy ? pc_r : ST_WAIT;
    end else if (cond_hit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/hcse_dp.sv =====
// datapath: registers, state, shared multiplier, accumulator, divider, result register
`default_nettype none

module hcse_dp
  import hcse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire uword_t                uw,
  input  wire logic                  item,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output out_item_t                  out_data,
  output status_t                    st
);

  // configuration
  logic [MODE_W-1:0] drive_mode_r, drive_mode_nxt;
  logic [GAIN_W-1:0] gain_new_r, gain_new_nxt;
  logic [GAIN_W-1:0] gain_old_r, gain_old_nxt;
  logic [RPM_W-1:0]  rpm_coeff_r, rpm_coeff_nxt;
  logic [CNT_W-1:0]  stall_limit_r, stall_limit_nxt;

  // tracked state
  logic [HALL_W-1:0] last_hall_r, last_hall_nxt;
  logic [CNT_W-1:0]  tc_r, tc_nxt;
  logic [CNT_W-1:0]  cf_r, cf_nxt;
  logic [RPM_W-1:0]  rnow_r, rnow_nxt;
  logic [RPM_W-1:0]  rs_r, rs_nxt;

  // per-item working registers
  logic [HALL_W-1:0] hall_r, hall_nxt;
  logic              en_r, en_nxt;
  logic              chg_r, chg_nxt;
  logic              stall_r, stall_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [GAIN_W-1:0] mul_gain;
  logic [RPM_W-1:0]  mul_x;
  logic [ACC_W-1:0]  prod_q;
  logic              div_busy;
  logic [RPM_W-1:0]  div_quo;
  logic              out_busy;
  logic              fire;
  logic              mode_ok;
  logic [2:0]        pat;

  hcse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (uw.div_start),
    .dividend (rpm_coeff_r),
    .divisor  (cf_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign out_busy = out_valid_r && !out_ready;
  assign fire     = uw.emit && !out_busy;
  assign mode_ok  = (drive_mode_r == MODE_COMM_A) || (drive_mode_r == MODE_COMM_B);
  assign pat      = (chg_r && mode_ok) ? pattern_of_hall(hall_r) : PAT_NONE;
  assign prod_q   = ACC_W'(prod_r[PROD_W-1:Q_FRAC]);

  always_comb begin
    st.item      = item;
    st.enable    = en_r;
    st.same      = hall_r == last_hall_r;
    st.div_busy  = div_busy;
    st.stall_hit = tc_r >= stall_limit_r;
    st.out_busy  = out_busy;
  end

  // register writes
  always_comb begin
    drive_mode_nxt  = drive_mode_r;
    gain_new_nxt    = gain_new_r;
    gain_old_nxt    = gain_old_r;
    rpm_coeff_nxt   = rpm_coeff_r;
    stall_limit_nxt = stall_limit_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DRIVE_MODE:  drive_mode_nxt  = cfg_data[MODE_W-1:0];
        CFG_GAIN_NEW:    gain_new_nxt    = cfg_data[GAIN_W-1:0];
        CFG_GAIN_OLD:    gain_old_nxt    = cfg_data[GAIN_W-1:0];
        CFG_RPM_COEFF:   rpm_coeff_nxt   = cfg_data[RPM_W-1:0];
        CFG_STALL_LIMIT: stall_limit_nxt = cfg_data[CNT_W-1:0];
        default:         drive_mode_nxt  = drive_mode_r;
      endcase
    end
  end

  // multiplier operands
  always_comb begin
    case (uw.mul)
      MUL_GO_CF: begin
        mul_gain = gain_old_r;
        mul_x    = RPM_W'(cf_r);
      end
      MUL_GN_TC: begin
        mul_gain = gain_new_r;
        mul_x    = RPM_W'(tc_r);
      end
      MUL_GO_RS: begin
        mul_gain = gain_old_r;
        mul_x    = rs_r;
      end
      MUL_GN_RNOW: begin
        mul_gain = gain_new_r;
        mul_x    = rnow_r;
      end
      default: begin
        mul_gain = gain_new_r;
        mul_x    = rnow_r;
      end
    endcase
  end

  always_comb begin
    prod_nxt = (uw.mul == MUL_NONE) ? prod_r : PROD_W'(mul_gain) * PROD_W'(mul_x);

    case (uw.acc)
      ACC_LOAD: acc_nxt = prod_q;
      ACC_ADD:  acc_nxt = acc_r + prod_q;
      default:  acc_nxt = acc_r;
    endcase

    hall_nxt  = hall_r;
    en_nxt    = en_r;
    chg_nxt   = chg_r || uw.set_chg;
    stall_nxt = stall_r;
    if (item) begin
      hall_nxt  = in_data.hall_code;
      en_nxt    = in_data.drive_enable;
      chg_nxt   = 1'b0;
      stall_nxt = 1'b0;
    end

    tc_nxt   = tc_r;
    cf_nxt   = cf_r;
    rnow_nxt = rnow_r;
    rs_nxt   = rs_r;
    case (uw.wr)
      WR_CF:     cf_nxt = (acc_r > ACC_W'(CNT_MAX)) ? CNT_MAX : acc_r[CNT_W-1:0];
      WR_RNOW:   rnow_nxt = (cf_r == '0) ? rpm_coeff_r : div_quo;
      WR_RS:     rs_nxt = (acc_r > ACC_W'(RPM_MAX)) ? RPM_MAX : acc_r[RPM_W-1:0];
      WR_TC_CLR: tc_nxt = '0;
      WR_TC_INC: tc_nxt = tc_r + CNT_W'(1);
      WR_STALL: begin
        tc_nxt    = '0;
        rs_nxt    = '0;
        stall_nxt = 1'b1;
      end
      default:   tc_nxt = tc_r;
    endcase

    last_hall_nxt = fire ? hall_r : last_hall_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (fire) begin
      out_valid_nxt         = 1'b1;
      out_nxt.commutate     = pat != PAT_NONE;
      out_nxt.phase_pattern = pat;
      out_nxt.rpm_est       = rnow_r;
      out_nxt.rpm_est_filt  = rs_r;
      out_nxt.stall_res     = stall_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r  <= DRIVE_MODE_RST;
      gain_new_r    <= GAIN_NEW_RST;
      gain_old_r    <= GAIN_OLD_RST;
      rpm_coeff_r   <= RPM_COEFF_RST;
      stall_limit_r <= STALL_LIMIT_RST;
      last_hall_r   <= '0;
      tc_r          <= '0;
      cf_r          <= '0;
      rnow_r        <= '0;
      rs_r          <= '0;
      chg_r         <= 1'b0;
      stall_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      drive_mode_r  <= drive_mode_nxt;
      gain_new_r    <= gain_new_nxt;
      gain_old_r    <= gain_old_nxt;
      rpm_coeff_r   <= rpm_coeff_nxt;
      stall_limit_r <= stall_limit_nxt;
      last_hall_r   <= last_hall_nxt;
      tc_r          <= tc_nxt;
      cf_r          <= cf_nxt;
      rnow_r        <= rnow_nxt;
      rs_r          <= rs_nxt;
      chg_r         <= chg_nxt;
      stall_r       <= stall_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hall_r <= hall_nxt;
    en_r   <= en_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/hall_commutation_speed_estimator_core.sv =====
// top level of the hall six-step commutation and speed estimator
`default_nettype none

// One item per pwm tick: hall code plus drive enable in, one result out
// (bridge pattern, raw and filtered rpm, stall flag). A small microprogram
// steps a shared 11x17 multiplier, an accumulator and a restoring divider.
// With drive disabled an item goes straight to the emit step; an unchanged
// hall code bumps the tick count and may declare a stall; a hall change runs
// the count filter, then waits at the divide wait step while the divider
// forms 17 quotient bits of the rpm coefficient over the filtered count,
// then runs the speed filter. A new item is taken as soon as the sequencer
// is back at its wait step, even while the last result still sits in the
// output register; the final step only stalls while that register is still full.
// Config writes are taken every cycle (cfg_ready tied high) and are meant to
// happen only while the block is idle. No clearing pass after reset: all
// state is in flip-flops.

`include "hall_commutation_speed_estimator_core_assert.svh"

module hall_commutation_speed_estimator_core
  import hcse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tick input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  uword_t  uw;
  status_t st;
  logic    idle;
  logic    item;

  // item accepted only at the wait step of the program
  assign in_ready  = idle;
  assign item      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  hcse_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw),
    .idle  (idle)
  );

  hcse_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .uw        (uw),
    .item      (item),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

  // an accepted item leaves the sequencer busy in the next cycle
  `HCSE_ASSERT_NEXT(a_item_busy, item, !in_ready)
  // a commutation always carries a real bridge pattern
  `HCSE_ASSERT_NOW(a_comm_pat, out_valid && out_data.commutate, out_data.phase_pattern != PAT_NONE)
  // a stall tick never commutates
  `HCSE_ASSERT_NOW(a_stall_quiet, out_valid && out_data.stall_res, !out_data.commutate)

endmodule

`default_nettype wire
